// ===== rtl/core/sifr_pkg.sv =====
// package for the stuffed I-frame receiver: line codes, result kinds,
// hunt state codes, counter widths and the result struct
// no dependencies
package sifr_pkg;

    // frame size limit, in payload bytes
    localparam int MAX_PAYLOAD = 1024;

    // byte counter covers up to twice the limit of destuffed bytes
    localparam int CNT_W = $clog2(2 * MAX_PAYLOAD);
    localparam logic [CNT_W:0] STORE_LIMIT = (CNT_W + 1)'(2 * MAX_PAYLOAD);

    // fixed field widths
    localparam int BYTE_W      = 8;
    localparam int KIND_W      = 3;
    localparam int FRAME_LEN_W = 12;
    localparam int HUNT_W      = 3;

    typedef logic [BYTE_W-1:0]      byte_t;
    typedef logic [KIND_W-1:0]      kind_t;
    typedef logic [FRAME_LEN_W-1:0] frame_len_t;
    typedef logic [CNT_W-1:0]       count_t;
    typedef logic [HUNT_W-1:0]      hunt_t;

    // line bytes
    localparam byte_t B_FLAG = 8'h7E;
    localparam byte_t B_ADDR = 8'h03;
    localparam byte_t B_ESC  = 8'h7D;
    localparam byte_t B_XOR  = 8'h20;

    // control bytes
    localparam byte_t C_I0   = 8'h00;
    localparam byte_t C_I1   = 8'h80;
    localparam byte_t C_RR0  = 8'h05;
    localparam byte_t C_RR1  = 8'h85;
    localparam byte_t C_REJ0 = 8'h01;
    localparam byte_t C_REJ1 = 8'h81;

    // result kinds
    localparam kind_t KIND_PAYLOAD   = 3'd0;
    localparam kind_t KIND_GOOD      = 3'd1;
    localparam kind_t KIND_CHECK_ERR = 3'd2;
    localparam kind_t KIND_DUPLICATE = 3'd3;
    localparam kind_t KIND_OVERFLOW  = 3'd4;

    // hunt state codes
    localparam hunt_t HS_START = 3'd0;
    localparam hunt_t HS_FLAG  = 3'd1;
    localparam hunt_t HS_ADDR  = 3'd2;
    localparam hunt_t HS_CTRL  = 3'd3;
    localparam hunt_t HS_DATA  = 3'd4;

    // one result beat as produced by the deframer
    typedef struct packed {
        logic       valid;
        kind_t      kind;
        byte_t      data;
        frame_len_t len;
    } result_t;

endpackage

// ===== rtl/core/sifr_deframer.sv =====
// deframer core: header hunt, destuffing, hold-back byte, parity and verdict
// depends on sifr_pkg
module sifr_deframer (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             accept,
    input  sifr_pkg::byte_t  rx_byte,
    output sifr_pkg::result_t res
);
    import sifr_pkg::*;

    hunt_t  hunt_reg, hunt_next;
    logic   esc_reg, esc_next;
    byte_t  ctrl_reg, ctrl_next;
    logic   seq_reg, seq_next;
    byte_t  parity_reg, parity_next;
    byte_t  held_reg, held_next;
    logic   held_valid_reg, held_valid_next;
    count_t count_reg, count_next;

    byte_t          rr_ctrl;
    byte_t          want_ctrl;
    byte_t          destuffed;
    logic [CNT_W:0] stored;

    assign rr_ctrl   = seq_reg ? C_RR0 : C_RR1;
    assign want_ctrl = seq_reg ? C_I1 : C_I0;
    assign destuffed = esc_reg ? (rx_byte ^ B_XOR) : rx_byte;
    assign stored    = {1'b0, count_reg} + {{CNT_W{1'b0}}, held_valid_reg};

    // next state and result for one line byte
    always_comb begin
        hunt_next       = hunt_reg;
        esc_next        = esc_reg;
        ctrl_next       = ctrl_reg;
        seq_next        = seq_reg;
        parity_next     = parity_reg;
        held_next       = held_reg;
        held_valid_next = held_valid_reg;
        count_next      = count_reg;
        res             = '0;

        unique case (hunt_reg)
            HS_FLAG: begin
                if (rx_byte == B_FLAG) begin
                    hunt_next = HS_FLAG;
                end else if (rx_byte == B_ADDR) begin
                    hunt_next = HS_ADDR;
                end else begin
                    hunt_next = HS_START;
                end
            end
            HS_ADDR: begin
                if (rx_byte == B_FLAG) begin
                    hunt_next = HS_FLAG;
                end else begin
                    ctrl_next = rx_byte;
                    hunt_next = HS_CTRL;
                end
            end
            HS_CTRL: begin
                if (rx_byte == B_FLAG) begin
                    hunt_next = HS_FLAG;
                end else if (rx_byte == (B_ADDR ^ ctrl_reg) &&
                             (ctrl_reg == C_I0 || ctrl_reg == C_I1)) begin
                    if (ctrl_reg != want_ctrl) begin
                        // wrong sequence: acknowledge again, drop the frame
                        hunt_next = HS_START;
                        res.valid = 1'b1;
                        res.kind  = KIND_DUPLICATE;
                        res.data  = rr_ctrl;
                    end else begin
                        esc_next        = 1'b0;
                        parity_next     = '0;
                        held_next       = '0;
                        held_valid_next = 1'b0;
                        count_next      = '0;
                        hunt_next       = HS_DATA;
                    end
                end else begin
                    hunt_next = HS_START;
                end
            end
            HS_DATA: begin
                if (rx_byte == B_FLAG) begin
                    if (!held_valid_reg) begin
                        // empty data part: flag counts as an opening flag
                        esc_next  = 1'b0;
                        hunt_next = HS_FLAG;
                    end else begin
                        hunt_next       = HS_START;
                        esc_next        = 1'b0;
                        parity_next     = '0;
                        held_next       = '0;
                        held_valid_next = 1'b0;
                        count_next      = '0;
                        res.valid       = 1'b1;
                        if (held_reg == parity_reg) begin
                            seq_next = ~seq_reg;
                            res.kind = KIND_GOOD;
                            res.data = rr_ctrl;
                            res.len  = FRAME_LEN_W'(count_reg);
                        end else begin
                            res.kind = KIND_CHECK_ERR;
                            res.data = seq_reg ? C_REJ1 : C_REJ0;
                        end
                    end
                end else if (rx_byte == B_ESC) begin
                    esc_next = 1'b1;
                end else begin
                    esc_next = 1'b0;
                    if (stored >= STORE_LIMIT) begin
                        // frame too long: discard
                        parity_next     = '0;
                        held_next       = '0;
                        held_valid_next = 1'b0;
                        count_next      = '0;
                        hunt_next       = HS_START;
                        res.valid       = 1'b1;
                        res.kind        = KIND_OVERFLOW;
                    end else if (held_valid_reg) begin
                        // release the held byte, hold back the new one
                        parity_next = parity_reg ^ held_reg;
                        count_next  = count_reg + 1'b1;
                        held_next   = destuffed;
                        res.valid   = 1'b1;
                        res.kind    = KIND_PAYLOAD;
                        res.data    = held_reg;
                    end else begin
                        held_next       = destuffed;
                        held_valid_next = 1'b1;
                    end
                end
            end
            default: begin
                hunt_next = (rx_byte == B_FLAG) ? HS_FLAG : HS_START;
            end
        endcase
    end

    // state registers, updated on each accepted beat
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hunt_reg       <= HS_START;
            esc_reg        <= 1'b0;
            ctrl_reg       <= '0;
            seq_reg        <= 1'b0;
            parity_reg     <= '0;
            held_reg       <= '0;
            held_valid_reg <= 1'b0;
            count_reg      <= '0;
        end else if (accept) begin
            hunt_reg       <= hunt_next;
            esc_reg        <= esc_next;
            ctrl_reg       <= ctrl_next;
            seq_reg        <= seq_next;
            parity_reg     <= parity_next;
            held_reg       <= held_next;
            held_valid_reg <= held_valid_next;
            count_reg      <= count_next;
        end
    end

endmodule

// ===== rtl/core/sifr_out_reg.sv =====
// result register on the m_ side; holds the input side while a beat waits
// depends on sifr_pkg
module sifr_out_reg (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 load,
    input  sifr_pkg::result_t    res,
    input  logic                 m_ready,
    output logic                 m_valid,
    output logic                 space,
    output sifr_pkg::kind_t      m_result_kind,
    output sifr_pkg::byte_t      m_result_byte,
    output sifr_pkg::frame_len_t m_frame_length
);
    import sifr_pkg::*;

    logic       valid_reg;
    kind_t      kind_reg;
    byte_t      data_reg;
    frame_len_t len_reg;

    // room for a new result when empty or the current one leaves now
    assign space = !valid_reg || m_ready;

    // valid flag
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (space) begin
            valid_reg <= load && res.valid;
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        if (space && load && res.valid) begin
            kind_reg <= res.kind;
            data_reg <= res.data;
            len_reg  <= res.len;
        end
    end

    assign m_valid        = valid_reg;
    assign m_result_kind  = kind_reg;
    assign m_result_byte  = data_reg;
    assign m_frame_length = len_reg;

endmodule

// ===== rtl/core/stuffed_iframe_receiver.sv =====
// Stop-and-wait I-frame receiver with byte destuffing. Each s_ beat carries
// one raw line byte; the block takes one byte per clock and answers with at
// most one m_ beat the cycle after the byte is taken: a destuffed payload
// byte (sent one byte late, so the trailing check byte never appears), or
// on the closing flag a verdict with the control byte to send back (good
// frame with RR, check error with REJ), a duplicate-sequence RR after the
// header, or an overflow discard. Payload leaves before the verdict; drop
// it unless the verdict is frame good. The rate of one byte per cycle is
// set by the single deframer state update between s_ and the result
// register; s_ready falls only while a result waits on m_ready.
// depends on sifr_pkg, sifr_deframer, sifr_out_reg
module stuffed_iframe_receiver (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  sifr_pkg::byte_t      s_rx_byte,
    output logic                 m_valid,
    input  logic                 m_ready,
    output sifr_pkg::kind_t      m_result_kind,
    output sifr_pkg::byte_t      m_result_byte,
    output sifr_pkg::frame_len_t m_frame_length
);
    import sifr_pkg::*;

    result_t res;
    logic    accept;
    logic    space;

    assign s_ready = space;
    assign accept  = s_valid && space;

    // header hunt and destuffing
    sifr_deframer u_deframer (
        .aclk    (aclk),
        .aresetn (aresetn),
        .accept  (accept),
        .rx_byte (s_rx_byte),
        .res     (res)
    );

    // result register
    sifr_out_reg u_out_reg (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .load           (accept),
        .res            (res),
        .m_ready        (m_ready),
        .m_valid        (m_valid),
        .space          (space),
        .m_result_kind  (m_result_kind),
        .m_result_byte  (m_result_byte),
        .m_frame_length (m_frame_length)
    );

endmodule

// ===== rtl/core/sifr_checker.sv =====
// port-level checks for the stuffed I-frame receiver, bound to the top level
// depends on sifr_pkg
module sifr_checker (
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_valid,
    input logic                 s_ready,
    input sifr_pkg::byte_t      s_rx_byte,
    input logic                 m_valid,
    input logic                 m_ready,
    input sifr_pkg::kind_t      m_result_kind,
    input sifr_pkg::byte_t      m_result_byte,
    input sifr_pkg::frame_len_t m_frame_length
);
    import sifr_pkg::*;

    // a stalled result beat holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_result_kind) &&
        $stable(m_result_byte) && $stable(m_frame_length))
        else $error("result beat changed while stalled");

    // input side is open whenever no result waits
    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("input stalled with empty result register");

    // length is only carried by a good frame
    a_len: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_result_kind != KIND_GOOD |-> m_frame_length == '0)
        else $error("frame length on a non-good result");

    // verdicts carry a legal response control
    a_ctrl: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_result_kind == KIND_GOOD || m_result_kind == KIND_DUPLICATE)
        |-> m_result_byte == C_RR0 || m_result_byte == C_RR1)
        else $error("bad RR control");

    // a result follows only an accepted input beat
    a_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(s_valid && s_ready))
        else $error("result without an input beat");

endmodule

bind stuffed_iframe_receiver sifr_checker u_sifr_checker (.*);

// ===== bench/sifr_result_checker.sv =====
// result checker for the stuffed I-frame receiver: follows the deframer state
// from every accepted line byte and compares each result beat in order
// depends on sifr_pkg
module sifr_result_checker (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    input  logic                 s_ready,
    input  sifr_pkg::byte_t      s_rx_byte,
    input  logic                 m_valid,
    input  logic                 m_ready,
    input  sifr_pkg::kind_t      m_result_kind,
    input  sifr_pkg::byte_t      m_result_byte,
    input  sifr_pkg::frame_len_t m_frame_length,
    output int                   mismatch_count,
    output int                   pending_beats
);
    import sifr_pkg::*;

    typedef struct packed {
        kind_t      kind;
        byte_t      data;
        frame_len_t len;
    } beat_t;

    // predicted deframer state
    hunt_t stage;
    bit    esc_armed;
    byte_t ctrl_byte;
    bit    want_seq;
    byte_t parity_acc;
    byte_t holdback;
    bit    holdback_full;
    int    delivered;

    beat_t expected_beats[$];

    function automatic void clear_frame();
        esc_armed     = 1'b0;
        parity_acc    = '0;
        holdback      = '0;
        holdback_full = 1'b0;
        delivered     = 0;
    endfunction

    function automatic beat_t make_beat(kind_t k, byte_t d, frame_len_t n);
        beat_t r;
        r.kind = k;
        r.data = d;
        r.len  = n;
        return r;
    endfunction

    // advance the deframer by one line byte; returns 1 when a beat results
    function automatic bit deframe_byte(input byte_t b, output beat_t r);
        byte_t ack;
        byte_t v;
        bit    fires;
        ack   = want_seq ? C_RR0 : C_RR1;
        fires = 1'b0;
        r     = make_beat(KIND_PAYLOAD, '0, '0);
        case (stage)
            HS_FLAG: begin
                if (b == B_FLAG)
                    stage = HS_FLAG;
                else if (b == B_ADDR)
                    stage = HS_ADDR;
                else
                    stage = HS_START;
            end
            HS_ADDR: begin
                if (b == B_FLAG) begin
                    stage = HS_FLAG;
                end else begin
                    ctrl_byte = b;
                    stage     = HS_CTRL;
                end
            end
            HS_CTRL: begin
                if (b == B_FLAG) begin
                    stage = HS_FLAG;
                end else if (b == (B_ADDR ^ ctrl_byte) &&
                             (ctrl_byte == C_I0 || ctrl_byte == C_I1)) begin
                    // header fine; the sequence bit decides
                    if (ctrl_byte != (want_seq ? C_I1 : C_I0)) begin
                        stage = HS_START;
                        r     = make_beat(KIND_DUPLICATE, ack, '0);
                        fires = 1'b1;
                    end else begin
                        clear_frame();
                        stage = HS_DATA;
                    end
                end else begin
                    stage = HS_START;
                end
            end
            HS_DATA: begin
                if (b == B_FLAG) begin
                    if (!holdback_full) begin
                        // nothing destuffed yet: acts as an opening flag
                        esc_armed = 1'b0;
                        stage     = HS_FLAG;
                    end else begin
                        // closing flag: held byte is the check byte
                        stage = HS_START;
                        if (holdback == parity_acc) begin
                            r        = make_beat(KIND_GOOD, ack, frame_len_t'(delivered));
                            want_seq = ~want_seq;
                        end else begin
                            r = make_beat(KIND_CHECK_ERR, want_seq ? C_REJ1 : C_REJ0, '0);
                        end
                        clear_frame();
                        fires = 1'b1;
                    end
                end else if (b == B_ESC) begin
                    esc_armed = 1'b1;
                end else begin
                    v         = esc_armed ? (b ^ B_XOR) : b;
                    esc_armed = 1'b0;
                    if (delivered + holdback_full >= 2 * MAX_PAYLOAD) begin
                        clear_frame();
                        stage = HS_START;
                        r     = make_beat(KIND_OVERFLOW, '0, '0);
                        fires = 1'b1;
                    end else if (holdback_full) begin
                        r          = make_beat(KIND_PAYLOAD, holdback, '0);
                        parity_acc = parity_acc ^ holdback;
                        delivered  = delivered + 1;
                        holdback   = v;
                        fires      = 1'b1;
                    end else begin
                        holdback      = v;
                        holdback_full = 1'b1;
                    end
                end
            end
            default: stage = (b == B_FLAG) ? HS_FLAG : HS_START;
        endcase
        return fires;
    endfunction

    always @(posedge aclk) begin : track
        beat_t oldest;
        beat_t fresh;
        if (!aresetn) begin
            stage     = HS_START;
            ctrl_byte = '0;
            want_seq  = 1'b0;
            clear_frame();
            expected_beats.delete();
            mismatch_count <= 0;
        end else begin
            // result beat against the oldest expectation
            if (m_valid && m_ready) begin
                if (expected_beats.size() == 0) begin
                    $display("%0t: unexpected result beat: kind %0d byte %02h length %0d",
                             $time, m_result_kind, m_result_byte, m_frame_length);
                    mismatch_count <= mismatch_count + 1;
                end else begin
                    oldest = expected_beats.pop_front();
                    if (m_result_kind !== oldest.kind || m_result_byte !== oldest.data ||
                        m_frame_length !== oldest.len) begin
                        $display("%0t: expected kind %0d byte %02h length %0d", $time,
                                 oldest.kind, oldest.data, oldest.len);
                        $display("%0t: actual   kind %0d byte %02h length %0d", $time,
                                 m_result_kind, m_result_byte, m_frame_length);
                        mismatch_count <= mismatch_count + 1;
                    end
                end
            end
            // line byte beat
            if (s_valid && s_ready) begin
                if (deframe_byte(s_rx_byte, fresh))
                    expected_beats.push_back(fresh);
            end
        end
        pending_beats <= expected_beats.size();
    end

endmodule

// ===== bench/stuffed_iframe_receiver_test.sv =====
// testbench top for the stuffed I-frame receiver: sends framed line bytes
// with random gaps and result stalls, then gives the verdict
// depends on sifr_pkg, stuffed_iframe_receiver, sifr_result_checker
module stuffed_iframe_receiver_test;
    import sifr_pkg::*;

    localparam int ITEMS          = 600;
    localparam int QUIET_TAIL     = 100;
    localparam int WATCHDOG_LIMIT = 2000;

    logic       aclk;
    logic       aresetn;
    logic       s_valid;
    logic       s_ready;
    byte_t      s_rx_byte;
    logic       m_valid;
    logic       m_ready;
    kind_t      m_result_kind;
    byte_t      m_result_byte;
    frame_len_t m_frame_length;
    int         mismatch_count;
    int         pending_beats;

    bit tx_seq       = 1'b0;  // sequence bit the receiver should want next
    bit idle_en      = 1'b1;
    int n_sent       = 0;
    int quiet_cycles = 0;
    int n_good       = 0;
    int n_bad_check  = 0;
    int n_dup        = 0;
    int n_junk       = 0;

    stuffed_iframe_receiver u_top (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_rx_byte      (s_rx_byte),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_result_kind  (m_result_kind),
        .m_result_byte  (m_result_byte),
        .m_frame_length (m_frame_length)
    );

    sifr_result_checker u_check (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_rx_byte      (s_rx_byte),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_result_kind  (m_result_kind),
        .m_result_byte  (m_result_byte),
        .m_frame_length (m_frame_length),
        .mismatch_count (mismatch_count),
        .pending_beats  (pending_beats)
    );

    always begin
        aclk = 1'b0;
        #1;
        aclk = 1'b1;
        #1;
    end

    // result side stalls in bursts
    initial begin
        m_ready = 1'b0;
        forever begin
            if (idle_en && $urandom_range(0, 5) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 16)) @(posedge aclk);
            end else begin
                m_ready <= 1'b1;
                repeat ($urandom_range(1, 20)) @(posedge aclk);
            end
        end
    end

    // watchdog on cycles with no beat on either channel
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no beat moved for %0d cycles", $time, quiet_cycles);
            $display("stuffed_iframe_receiver_test: done, errors");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // one line byte beat, with an optional gap before it
    task automatic send_byte(input byte_t b);
        if (idle_en && $urandom_range(0, 11) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_rx_byte <= b;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        n_sent++;
    endtask

    // stuffed data byte; ordinary bytes get escaped now and then as well
    task automatic send_data(input byte_t b, input bit force_esc);
        bit can_escape;
        can_escape = ((b ^ B_XOR) != B_FLAG) && ((b ^ B_XOR) != B_ESC);
        if (b == B_FLAG || b == B_ESC ||
            (can_escape && (force_esc || $urandom_range(0, 24) == 0))) begin
            send_byte(B_ESC);
            send_byte(b ^ B_XOR);
        end else begin
            send_byte(b);
        end
    endtask

    function automatic byte_t rand_payload();
        case ($urandom_range(0, 9))
            0:       return B_FLAG;
            1:       return B_ESC;
            default: return byte_t'($urandom);
        endcase
    endfunction

    function automatic byte_t ctrl_for(input bit seq);
        return seq ? C_I1 : C_I0;
    endfunction

    // whole frame: header, stuffed payload, check byte, closing flag
    task automatic send_frame(input byte_t ctrl, input byte_t hcs, input int len,
                              input bit bad_check, input bit esc_last);
        byte_t parity;
        byte_t p;
        parity = '0;
        send_byte(B_FLAG);
        send_byte(B_ADDR);
        send_byte(ctrl);
        send_byte(hcs);
        for (int i = 0; i < len; i++) begin
            p      = rand_payload();
            parity = parity ^ p;
            send_data(p, 1'b0);
        end
        if (bad_check)
            parity = parity ^ byte_t'(1 << $urandom_range(0, 7));
        send_data(parity, esc_last);
        send_byte(B_FLAG);
    endtask

    // hold off until every expected result has come out
    task automatic drain_results();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending_beats != 0) @(posedge aclk);
    endtask

    initial begin
        aresetn   = 1'b0;
        s_valid   = 1'b0;
        s_rx_byte = '0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        // repeated flags, flag right after the header, frame of only a check byte
        send_byte(B_FLAG); send_byte(B_FLAG); send_byte(B_ADDR); send_byte(C_I0);
        send_byte(B_ADDR ^ C_I0); send_byte(B_FLAG);
        send_byte(B_ADDR); send_byte(C_I0); send_byte(B_ADDR ^ C_I0);
        send_byte(8'h00); send_byte(B_FLAG);
        // same sequence bit again
        send_byte(B_FLAG); send_byte(B_ADDR); send_byte(C_I0); send_byte(B_ADDR ^ C_I0);
        // flag instead of the header check, double escape, escape before the flag
        send_byte(B_FLAG); send_byte(B_ADDR); send_byte(C_I1); send_byte(B_FLAG);
        send_byte(B_ADDR); send_byte(C_I1); send_byte(B_ADDR ^ C_I1);
        send_byte(8'hFF); send_byte(B_ESC); send_byte(B_ESC); send_byte(B_FLAG ^ B_XOR);
        send_byte(8'hFF ^ B_FLAG); send_byte(B_ESC); send_byte(B_FLAG);
        // wrong check byte
        send_byte(B_FLAG); send_byte(B_ADDR); send_byte(C_I0); send_byte(B_ADDR ^ C_I0);
        send_byte(8'h55); send_byte(8'h54); send_byte(B_FLAG);
        drain_results();

        // random frames, mostly well formed
        tx_seq = 1'b0;
        for (int f = 0; n_sent < ITEMS; f++) begin
            int    len;
            int    pick;
            byte_t ctrl;
            byte_t hcs;
            idle_en = (n_sent < ITEMS - QUIET_TAIL) && ($urandom_range(0, 3) != 0);
            pick    = $urandom_range(0, 19);
            if (pick < 15)
                len = $urandom_range(0, 8);
            else if (pick < 19)
                len = $urandom_range(9, 40);
            else
                len = $urandom_range(41, 200);
            ctrl = ctrl_for(tx_seq);
            pick = $urandom_range(0, 99);
            if (pick < 64) begin
                send_frame(ctrl, B_ADDR ^ ctrl, len, 1'b0, 1'b0);
                tx_seq = ~tx_seq;
                n_good++;
            end else if (pick < 74) begin
                send_frame(ctrl, B_ADDR ^ ctrl, len, 1'b1, 1'b0);
                n_bad_check++;
            end else if (pick < 82) begin
                ctrl = ctrl_for(~tx_seq);
                send_frame(ctrl, B_ADDR ^ ctrl, len, 1'b0, 1'b0);
                n_dup++;
            end else if (pick < 88) begin
                // broken header: any control, header check usually off
                ctrl = byte_t'($urandom);
                if (ctrl == C_I0 || ctrl == C_I1 || $urandom_range(0, 1) == 0)
                    hcs = B_ADDR ^ ctrl ^ byte_t'($urandom_range(1, 255));
                else
                    hcs = B_ADDR ^ ctrl;
                send_frame(ctrl, hcs, len, 1'b0, 1'b0);
                n_junk++;
            end else if (pick < 94) begin
                // header with no data
                send_byte(B_FLAG); send_byte(B_ADDR); send_byte(ctrl);
                send_byte(B_ADDR ^ ctrl); send_byte(B_FLAG);
                n_junk++;
            end else begin
                repeat ($urandom_range(1, 8)) send_byte(byte_t'($urandom));
                n_junk++;
            end
            if (f % 20 == 19)
                drain_results();
        end

        idle_en = 1'b0;
        drain_results();
        repeat (4) @(posedge aclk);

        $display("sent %0d line bytes: header, escape and flag corner cases, then random frames",
                 n_sent);
        $display("random frames: %0d good, %0d bad check, %0d stale sequence, %0d junk or empty",
                 n_good, n_bad_check, n_dup, n_junk);
        if (mismatch_count == 0 && pending_beats == 0)
            $display("stuffed_iframe_receiver_test: done, clean");
        else
            $display("stuffed_iframe_receiver_test: done, errors");
        $finish;
    end

endmodule
